// ===== rtl/core/efl_pkg.sv =====
// Package: shared types and constants of the free list allocator.
`default_nettype none
package efl_pkg;
  localparam int BA_W = 20;
  localparam int WD_W = 17;
  localparam logic [WD_W-1:0] NIL = 17'h1FFFF;
  localparam logic [0:0] CMD_ALLOC = 1'b0;
  localparam logic [0:0] CMD_RELEASE = 1'b1;
  localparam logic [0:0] ST_DONE = 1'b0;
  localparam logic [0:0] ST_OOM = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_WALK, S_WCHK, S_WNXT, S_GROW,
    S_RM_NX, S_RM_PV, S_RM_LD, S_WQ, S_AL_RDB, S_AL_SPL, S_PUSH,
    S_RL_HDR, S_RL_LRD, S_RL_LCK, S_RL_RCK, S_RL_MRG, S_RL_RM2, S_RL_WR,
    S_DONE
  } efl_state_t;

  typedef struct packed {
    logic            we;
    logic [BA_W-1:0] waddr;
    logic [WD_W-1:0] wdata;
    logic            re;
    logic [BA_W-1:0] raddr;
  } efl_mem_req_t;
endpackage
`default_nettype wire

// ===== rtl/core/efl_if.sv =====
// Interfaces: request, result and configuration channels.
`default_nettype none
interface efl_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] request_size;
  logic [15:0] block_address;
  modport source (output valid, command, request_size, block_address, input ready);
  modport sink (input valid, command, request_size, block_address, output ready);
endinterface

interface efl_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] payload_address;
  logic        status;
  modport source (output valid, payload_address, status, input ready);
  modport sink (input valid, payload_address, status, output ready);
endinterface

interface efl_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/efl_heap_mem.sv =====
// Heap word memory: one write port, one read port, registered read data.
`default_nettype none
module efl_heap_mem #(
  parameter int HEAP_WORDS = 8192
) (
  input  wire logic                  clk,
  input  efl_pkg::efl_mem_req_t      req,
  output logic [efl_pkg::WD_W-1:0]   rdata
);
  import efl_pkg::*;
  localparam int IDX_W = $clog2(HEAP_WORDS);

  logic [WD_W-1:0] mem [HEAP_WORDS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[3 +: IDX_W]] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr[3 +: IDX_W]];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/efl_seq.sv =====
// Sequencer: list walk, split, growth, coalescing and list updates.
`default_nettype none
module efl_seq #(
  parameter int HEAP_WORDS = 8192
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  efl_in_if.sink                   in_req,
  efl_out_if.source                out_rsp,
  efl_cfg_if.sink                  cfg_wr,
  output efl_pkg::efl_mem_req_t    mreq,
  input  wire logic [efl_pkg::WD_W-1:0] rdata
);
  import efl_pkg::*;
  localparam int CNT_W = $clog2(HEAP_WORDS) + 1;
  localparam logic [CNT_W-1:0] WALK_MAX = CNT_W'(HEAP_WORDS);
  localparam logic [BA_W-1:0] CEIL_MAX = BA_W'(HEAP_WORDS * 8);

  efl_state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [WD_W-1:0] limit_r, head_r, head_nxt, top_r, top_nxt;
  logic [WD_W-1:0] a_r, a_nxt, cur_r, cur_nxt, nx_r, nx_nxt;
  logic [WD_W-1:0] size_r, size_nxt, ls_r, ls_nxt, rs_r, rs_nxt, push_r, push_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [15:0] p_r, p_nxt, oaddr_r, oaddr_nxt;
  logic ostat_r, ostat_nxt, lf_r, lf_nxt, rf_r, rf_nxt;
  logic [BA_W-1:0] f_r, f_nxt, rm_r, rm_nxt;
  logic [1:0] qi_r, qi_nxt;
  logic qe_r [4];
  logic qe_nxt [4];
  logic [BA_W-1:0] qa_r [4];
  logic [BA_W-1:0] qa_nxt [4];
  logic [WD_W-1:0] qd_r [4];
  logic [WD_W-1:0] qd_nxt [4];

  logic [BA_W-1:0] ceil_w, pb, rb, lh, rfa, s, diff, u;
  logic [WD_W-1:0] tot;
  logic split;

  assign in_req.ready = (state_r == S_IDLE);
  assign out_rsp.valid = (state_r == S_DONE);
  assign out_rsp.payload_address = oaddr_r;
  assign out_rsp.status = ostat_r;
  assign cfg_wr.ready = 1'b1;
  assign ceil_w = (BA_W'(limit_r) < CEIL_MAX) ? BA_W'(limit_r) : CEIL_MAX;
  assign pb = BA_W'(p_r);
  assign rb = f_r + BA_W'(8);
  assign lh = pb - BA_W'(56) - BA_W'(ls_r);
  assign rfa = rb + BA_W'(24) + BA_W'(rs_r);
  assign diff = BA_W'(rdata) - BA_W'(a_r);
  assign split = (rdata < a_r) || (diff > BA_W'(32));
  assign u = diff - BA_W'(32);
  assign s = BA_W'(cur_r) + BA_W'(32) + BA_W'(a_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r <= S_IDLE;
      limit_r <= 17'h10000;
      head_r <= NIL;
      top_r <= '0;
      qi_r <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      head_r <= head_nxt;
      top_r <= top_nxt;
      qi_r <= qi_nxt;
      if (cfg_wr.valid) begin
        limit_r <= cfg_wr.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt; cur_r <= cur_nxt; nx_r <= nx_nxt; size_r <= size_nxt;
    ls_r <= ls_nxt; rs_r <= rs_nxt; push_r <= push_nxt; n_r <= n_nxt;
    p_r <= p_nxt; oaddr_r <= oaddr_nxt; ostat_r <= ostat_nxt;
    lf_r <= lf_nxt; rf_r <= rf_nxt; f_r <= f_nxt; rm_r <= rm_nxt;
    qe_r <= qe_nxt; qa_r <= qa_nxt; qd_r <= qd_nxt;
  end

  always_comb begin
    state_nxt = state_r; ret_nxt = ret_r; head_nxt = head_r; top_nxt = top_r;
    a_nxt = a_r; cur_nxt = cur_r; nx_nxt = nx_r; size_nxt = size_r;
    ls_nxt = ls_r; rs_nxt = rs_r; push_nxt = push_r; n_nxt = n_r;
    p_nxt = p_r; oaddr_nxt = oaddr_r; ostat_nxt = ostat_r;
    lf_nxt = lf_r; rf_nxt = rf_r; f_nxt = f_r; rm_nxt = rm_r; qi_nxt = qi_r;
    qe_nxt = qe_r; qa_nxt = qa_r; qd_nxt = qd_r;
    mreq = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          oaddr_nxt = '0;
          ostat_nxt = ST_DONE;
          if (in_req.command == CMD_ALLOC) begin
            a_nxt = (WD_W'(in_req.request_size) + WD_W'(7)) & ~WD_W'(7);
            cur_nxt = head_r;
            n_nxt = '0;
            state_nxt = S_WALK;
          end else begin
            p_nxt = in_req.block_address;
            if (in_req.block_address[2:0] != 3'd0 || in_req.block_address < 16'd24) begin
              state_nxt = S_DONE;
            end else begin
              mreq.re = 1'b1;
              mreq.raddr = BA_W'(in_req.block_address) - BA_W'(24);
              state_nxt = S_RL_HDR;
            end
          end
        end
      end
      S_WALK: begin
        if (cur_r == NIL || n_r == WALK_MAX) begin
          state_nxt = S_GROW;
        end else begin
          mreq.re = 1'b1;
          mreq.raddr = BA_W'(cur_r);
          state_nxt = S_WCHK;
        end
      end
      S_WCHK: begin
        if (rdata >= a_r) begin
          rm_nxt = BA_W'(cur_r);
          ret_nxt = S_AL_RDB;
          state_nxt = S_RM_NX;
        end else begin
          mreq.re = 1'b1;
          mreq.raddr = BA_W'(cur_r) + BA_W'(8);
          state_nxt = S_WNXT;
        end
      end
      S_WNXT: begin
        cur_nxt = rdata;
        n_nxt = n_r + CNT_W'(1);
        state_nxt = S_WALK;
      end
      S_GROW: begin
        if (BA_W'(top_r) + BA_W'(32) + BA_W'(a_r) > ceil_w) begin
          ostat_nxt = ST_OOM;
          state_nxt = S_DONE;
        end else begin
          qe_nxt[0] = 1'b1; qa_nxt[0] = BA_W'(top_r); qd_nxt[0] = a_r | WD_W'(1);
          qe_nxt[1] = 1'b1; qa_nxt[1] = BA_W'(top_r) + BA_W'(8); qd_nxt[1] = NIL;
          qe_nxt[2] = 1'b1; qa_nxt[2] = BA_W'(top_r) + BA_W'(16); qd_nxt[2] = NIL;
          qe_nxt[3] = 1'b1; qa_nxt[3] = BA_W'(top_r) + BA_W'(24) + BA_W'(a_r);
          qd_nxt[3] = a_r | WD_W'(1);
          top_nxt = top_r + WD_W'(32) + a_r;
          oaddr_nxt = 16'(top_r + WD_W'(24));
          ret_nxt = S_DONE;
          state_nxt = S_WQ;
        end
      end
      S_RM_NX: begin
        mreq.re = 1'b1;
        mreq.raddr = rm_r + BA_W'(8);
        state_nxt = S_RM_PV;
      end
      S_RM_PV: begin
        nx_nxt = rdata;
        mreq.re = 1'b1;
        mreq.raddr = rm_r + BA_W'(16);
        state_nxt = S_RM_LD;
      end
      S_RM_LD: begin
        if (rdata == NIL) begin
          head_nxt = nx_r;
        end
        qe_nxt[0] = (rdata != NIL); qa_nxt[0] = BA_W'(rdata) + BA_W'(8); qd_nxt[0] = nx_r;
        qe_nxt[1] = (nx_r != NIL); qa_nxt[1] = BA_W'(nx_r) + BA_W'(16); qd_nxt[1] = rdata;
        qe_nxt[2] = 1'b1; qa_nxt[2] = rm_r + BA_W'(8); qd_nxt[2] = NIL;
        qe_nxt[3] = 1'b1; qa_nxt[3] = rm_r + BA_W'(16); qd_nxt[3] = NIL;
        state_nxt = S_WQ;
      end
      S_WQ: begin
        mreq.we = qe_r[qi_r];
        mreq.waddr = qa_r[qi_r];
        mreq.wdata = qd_r[qi_r];
        qi_nxt = qi_r + 2'd1;
        if (qi_r == 2'd3) begin
          state_nxt = ret_r;
        end
      end
      S_AL_RDB: begin
        mreq.re = 1'b1;
        mreq.raddr = BA_W'(cur_r);
        state_nxt = S_AL_SPL;
      end
      S_AL_SPL: begin
        oaddr_nxt = 16'(cur_r + WD_W'(24));
        if (split) begin
          qe_nxt[0] = 1'b1; qa_nxt[0] = BA_W'(cur_r); qd_nxt[0] = a_r | WD_W'(1);
          qe_nxt[1] = 1'b1; qa_nxt[1] = BA_W'(cur_r) + BA_W'(24) + BA_W'(a_r);
          qd_nxt[1] = a_r | WD_W'(1);
          qe_nxt[2] = 1'b1; qa_nxt[2] = s; qd_nxt[2] = u[WD_W-1:0];
          qe_nxt[3] = 1'b1; qa_nxt[3] = s + BA_W'(24) + u; qd_nxt[3] = u[WD_W-1:0];
          push_nxt = s[WD_W-1:0];
          ret_nxt = S_PUSH;
        end else begin
          qe_nxt[0] = 1'b1; qa_nxt[0] = BA_W'(cur_r); qd_nxt[0] = rdata | WD_W'(1);
          qe_nxt[1] = 1'b1; qa_nxt[1] = BA_W'(cur_r) + BA_W'(24) + BA_W'(rdata);
          qd_nxt[1] = rdata | WD_W'(1);
          qe_nxt[2] = 1'b0; qe_nxt[3] = 1'b0;
          ret_nxt = S_DONE;
        end
        state_nxt = S_WQ;
      end
      S_PUSH: begin
        qe_nxt[0] = 1'b1; qa_nxt[0] = BA_W'(push_r) + BA_W'(8); qd_nxt[0] = head_r;
        qe_nxt[1] = 1'b1; qa_nxt[1] = BA_W'(push_r) + BA_W'(16); qd_nxt[1] = NIL;
        qe_nxt[2] = (head_r != NIL); qa_nxt[2] = BA_W'(head_r) + BA_W'(16);
        qd_nxt[2] = push_r;
        qe_nxt[3] = 1'b0;
        head_nxt = push_r;
        ret_nxt = S_DONE;
        state_nxt = S_WQ;
      end
      S_RL_HDR: begin
        size_nxt = rdata & ~WD_W'(1);
        f_nxt = pb + BA_W'(rdata & ~WD_W'(1));
        if (!rdata[0] || pb + BA_W'(rdata & ~WD_W'(1)) + BA_W'(8) > BA_W'(top_r)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RL_LRD;
        end
      end
      S_RL_LRD: begin
        mreq.re = (p_r >= 16'd32);
        mreq.raddr = pb - BA_W'(32);
        state_nxt = S_RL_LCK;
      end
      S_RL_LCK: begin
        lf_nxt = (p_r >= 16'd32) && !rdata[0];
        ls_nxt = ((p_r >= 16'd32) && !rdata[0]) ? rdata : '0;
        mreq.re = (rb < BA_W'(top_r));
        mreq.raddr = rb;
        state_nxt = S_RL_RCK;
      end
      S_RL_RCK: begin
        rf_nxt = (rb < BA_W'(top_r)) && !rdata[0];
        rs_nxt = ((rb < BA_W'(top_r)) && !rdata[0]) ? rdata : '0;
        state_nxt = S_RL_MRG;
      end
      S_RL_MRG: begin
        if (lf_r) begin
          rm_nxt = lh;
          ret_nxt = rf_r ? S_RL_RM2 : S_RL_WR;
          state_nxt = S_RM_NX;
        end else if (rf_r) begin
          rm_nxt = rb;
          ret_nxt = S_RL_WR;
          state_nxt = S_RM_NX;
        end else begin
          state_nxt = S_RL_WR;
        end
      end
      S_RL_RM2: begin
        rm_nxt = rb;
        ret_nxt = S_RL_WR;
        state_nxt = S_RM_NX;
      end
      S_RL_WR: begin
        qe_nxt[0] = 1'b1; qe_nxt[1] = 1'b1; qe_nxt[2] = 1'b0; qe_nxt[3] = 1'b0;
        qd_nxt[0] = tot; qd_nxt[1] = tot;
        qa_nxt[0] = lf_r ? lh : pb - BA_W'(24);
        qa_nxt[1] = rf_r ? rfa : f_r;
        push_nxt = lf_r ? lh[WD_W-1:0] : WD_W'(pb - BA_W'(24));
        ret_nxt = S_PUSH;
        state_nxt = S_WQ;
      end
      S_DONE: begin
        if (out_rsp.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    tot = size_r + ls_r + rs_r + (lf_r ? WD_W'(32) : '0) + (rf_r ? WD_W'(32) : '0);
  end
endmodule
`default_nettype wire

// ===== rtl/core/explicit_free_list_allocator_unit.sv =====
// Top level: first fit boundary tag heap allocator with explicit free list.
// Channels: in_req carries allocate (command 0, request_size) or release
// (command 1, block_address) requests; out_rsp returns one result per request
// (payload_address, status 1 on out of memory); cfg_wr writes heap_limit_bytes.
// One request is in flight at a time; in_req.ready is high only when idle.
// An allocate walks the free list, reading each entry's size and next link;
// with no fit it grows the heap at its top, or returns out of memory status
// when that would pass the limit. Taking a listed block may split the
// remainder off and push it. A release is rejected on a bad address or
// header, else it merges free neighbors. All steps share the heap memory:
// every tag read waits for registered read data and writes go one a cycle.
// Reset clears the heap top, empties the free list and sets the limit to
// 65536; heap contents are not cleared. A result is held on out_rsp until
// taken; the block accepts no new request while it waits.
`default_nettype none
module explicit_free_list_allocator_unit #(
  parameter int HEAP_WORDS = 8192
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  efl_in_if.sink     in_req,
  efl_out_if.source  out_rsp,
  efl_cfg_if.sink    cfg_wr
);
  import efl_pkg::*;

  efl_mem_req_t    mreq;
  logic [WD_W-1:0] rdata;

  efl_heap_mem #(.HEAP_WORDS(HEAP_WORDS)) u_mem (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  efl_seq #(.HEAP_WORDS(HEAP_WORDS)) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .cfg_wr  (cfg_wr),
    .mreq    (mreq),
    .rdata   (rdata)
  );
endmodule
`default_nettype wire
